// File: rtl/core/sllc_pkg.sv
package sllc_pkg;

    // Angle format: FRAC_BITS = ANGLE_WIDTH - 3
    localparam int ANGLE_WIDTH   = 32;
    localparam int FRAC_BITS     = ANGLE_WIDTH - 3;
    localparam int CORDIC_STAGES = 28;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES + 1);

    // Residual angle width: folded residual stays well inside +-2 rad
    localparam int ZW  = FRAC_BITS + 3;
    // CORDIC x/y width: Q30 values with headroom
    localparam int XW  = 33;
    localparam int QW  = 2;

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] RADIUS_AT_RESET = 32'd1632803072;

    // Register indexes
    localparam logic [0:0] REG_ANGLE_DEG = 1'd0;
    localparam logic [0:0] REG_RADIUS    = 1'd1;

    // pi/2 in Q(FRAC_BITS), rounded half up
    localparam logic [63:0] HALFPI_W =
        (PI_Q60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
    localparam logic signed [ZW-1:0] HALFPI  = ZW'(HALFPI_W);
    localparam logic signed [ZW-1:0] QUARTER = ZW'(HALFPI_W >> 1);

    // pi/180 in Q38
    localparam logic [63:0] D2R = (PI_Q60 >> 22) / 64'd180;

    typedef logic signed [ZW-1:0] ang_t;
    typedef logic signed [XW-1:0] cs_t;

    // Slice state handed from one CORDIC cell to the next
    typedef struct packed {
        ang_t          z;
        cs_t           x;
        cs_t           y;
        logic [QW-1:0] q;
    } rot_t;

    // atan(2^-i) in Q(FRAC_BITS); elaboration-time constant per cell
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          k;
        int          e;
        acc = 64'd0;
        if (i == 0) begin
            acc = PI_Q60;
        end else begin
            for (k = 0; i * (2 * k + 1) <= 62; k++) begin
                e    = 62 - i * (2 * k + 1);
                term = (64'd1 << e) / 64'(2 * k + 1);
                if (k % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
        end
        return ZW'((acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
    endfunction

endpackage

// File: rtl/core/sllc_angle.sv
// Angle front end: unit conversion to Q(FRAC_BITS) radians, then quadrant fold.
// Two register stages; valid/enable supplied by the top level.
module sllc_angle (
    input  logic                    aclk,
    input  logic                    en,
    input  logic                    deg,
    input  logic signed [31:0]      angle,
    output sllc_pkg::rot_t          rot
);
    localparam int FULL = 360 << 22;
    localparam int HALF = 180 << 22;

    logic signed [31:0] wrap_w;
    logic signed [31:0] wrap_reg;
    logic               deg_reg;
    logic signed [31:0] raw_reg;
    logic signed [71:0] prod;
    logic signed [71:0] rad_wide;
    logic signed [sllc_pkg::ZW-1:0] rad;
    logic signed [sllc_pkg::ZW+1:0] r0;
    sllc_pkg::rot_t rot_next;
    sllc_pkg::rot_t rot_reg;

    // Exact wrap into [-180, 180): input range spans under two turns each side
    always_comb begin
        logic signed [33:0] a;
        a = 34'(angle);
        if (a >= 34'(HALF)) begin
            a = a - 34'(FULL);
        end
        if (a >= 34'(HALF)) begin
            a = a - 34'(FULL);
        end
        if (a < -34'(HALF)) begin
            a = a + 34'(FULL);
        end
        if (a < -34'(HALF)) begin
            a = a + 34'(FULL);
        end
        wrap_w = a[31:0];
    end

    // Stage 1: register wrapped degrees and raw radians
    always_ff @(posedge aclk) begin
        if (en) begin
            wrap_reg <= wrap_w;
            raw_reg  <= angle;
            deg_reg  <= deg;
        end
    end

    // Degrees times pi/180 (32 x 33 bits)
    assign prod = 72'(wrap_reg) * $signed({1'b0, 71'(sllc_pkg::D2R)});
    always_comb begin
        if (deg_reg) begin
            rad_wide = (prod + (72'sd1 <<< (59 - sllc_pkg::FRAC_BITS)))
                       >>> (60 - sllc_pkg::FRAC_BITS);
        end else if (sllc_pkg::FRAC_BITS >= 29) begin
            rad_wide = 72'(raw_reg) <<< (sllc_pkg::FRAC_BITS - 29);
        end else begin
            rad_wide = (72'(raw_reg) + (72'sd1 <<< (28 - sllc_pkg::FRAC_BITS)))
                       >>> (29 - sllc_pkg::FRAC_BITS);
        end
        rad = rad_wide[sllc_pkg::ZW-1:0];
    end

    // Fold: residual at most about 4 rad, so at most three half-pi steps
    always_comb begin
        logic signed [sllc_pkg::ZW+1:0] r;
        logic [sllc_pkg::QW-1:0]        q;
        r = (sllc_pkg::ZW+2)'(rad);
        q = '0;
        for (int k = 0; k < 3; k++) begin
            if (r > (sllc_pkg::ZW+2)'(sllc_pkg::QUARTER)) begin
                r = r - (sllc_pkg::ZW+2)'(sllc_pkg::HALFPI);
                q = q + 1'b1;
            end else if (r < -(sllc_pkg::ZW+2)'(sllc_pkg::QUARTER)) begin
                r = r + (sllc_pkg::ZW+2)'(sllc_pkg::HALFPI);
                q = q - 1'b1;
            end
        end
        r0         = r;
        rot_next.z = r0[sllc_pkg::ZW-1:0];
        rot_next.x = sllc_pkg::XW'(sllc_pkg::GAIN_Q30);
        rot_next.y = '0;
        rot_next.q = q;
    end

    // Stage 2
    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg <= rot_next;
        end
    end

    assign rot = rot_reg;
endmodule

// File: rtl/core/sllc_cell.sv
// One CORDIC rotation cell; shift and atan constant come from its place in the row.
module sllc_cell (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [sllc_pkg::STAGE_W-1:0] idx,
    input  logic signed [sllc_pkg::ZW-1:0] atan_c,
    input  sllc_pkg::rot_t              din,
    output sllc_pkg::rot_t              dout
);
    sllc_pkg::rot_t dout_next;
    sllc_pkg::rot_t dout_reg;
    sllc_pkg::cs_t  dx;
    sllc_pkg::cs_t  dy;

    assign dx = din.y >>> idx;
    assign dy = din.x >>> idx;

    // Rotate toward zero residual
    always_comb begin
        dout_next = din;
        if (!din.z[sllc_pkg::ZW-1]) begin
            dout_next.x = din.x - dx;
            dout_next.y = din.y + dy;
            dout_next.z = din.z - atan_c;
        end else begin
            dout_next.x = din.x + dx;
            dout_next.y = din.y - dy;
            dout_next.z = din.z + atan_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;
endmodule

// File: rtl/core/sllc_cordic.sv
// Row of CORDIC cells, then quadrant restore into cos/sin (one register stage).
module sllc_cordic (
    input  logic           aclk,
    input  logic           en,
    input  sllc_pkg::rot_t din,
    output sllc_pkg::cs_t  cos_o,
    output sllc_pkg::cs_t  sin_o
);
    sllc_pkg::rot_t chain [sllc_pkg::CORDIC_STAGES+1];
    sllc_pkg::cs_t  cos_next;
    sllc_pkg::cs_t  sin_next;
    sllc_pkg::cs_t  cos_reg;
    sllc_pkg::cs_t  sin_reg;

    assign chain[0] = din;

    for (genvar i = 0; i < sllc_pkg::CORDIC_STAGES; i++) begin : g_cell
        sllc_cell u_cell (
            .aclk   (aclk),
            .en     (en),
            .idx    (sllc_pkg::STAGE_W'(i)),
            .atan_c (sllc_pkg::atan_entry(i)),
            .din    (chain[i]),
            .dout   (chain[i+1])
        );
    end

    // Quadrant restore
    always_comb begin
        sllc_pkg::rot_t f;
        f = chain[sllc_pkg::CORDIC_STAGES];
        case (f.q)
            2'd0: begin cos_next = f.x;  sin_next = f.y;  end
            2'd1: begin cos_next = -f.y; sin_next = f.x;  end
            2'd2: begin cos_next = -f.x; sin_next = -f.y; end
            default: begin cos_next = f.y; sin_next = -f.x; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_o = cos_reg;
    assign sin_o = sin_reg;
endmodule

// File: rtl/core/spherical_lonlat_to_cartesian.sv
// Channel  | Direction | tdata fields (low bit first)         | tuser/tlast
// s_axis   | in        | lon_angle[31:0] lat_angle altitude   | none
// m_axis   | out       | x_pos[47:0] y_pos z_pos              | none
//
// Fully pipelined: one transaction per cycle unless m_axis_tready stalls the pipe; stages are
// angle front end 2, CORDIC row, restore 1, three multiply stages, output reg.
// Latency is set by the CORDIC cell row. Reset clears valid bits and loads config registers only.
// The whole pipe advances when the output register is empty or being taken,
// so a stall on m_axis_tready freezes every stage and back-pressures s_axis.
module spherical_lonlat_to_cartesian (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // lon_angle, lat_angle, altitude
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,   // x_pos, y_pos, z_pos
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int LAT = sllc_pkg::CORDIC_STAGES + 6;

    logic               deg_reg;
    logic [31:0]        radius_reg;
    logic               en;
    logic [LAT-1:0]     vld_reg;
    logic               out_vld_reg;
    sllc_pkg::rot_t     lon_rot;
    sllc_pkg::rot_t     lat_rot;
    sllc_pkg::cs_t      clon;
    sllc_pkg::cs_t      slon;
    sllc_pkg::cs_t      clat;
    sllc_pkg::cs_t      slat;
    logic signed [33:0] r_pipe_reg [sllc_pkg::CORDIC_STAGES+3];
    logic signed [33:0] r_next;
    logic signed [66:0] rc_prod_reg;
    logic signed [66:0] rz_prod_reg;
    logic signed [36:0] rc_reg;
    logic signed [47:0] z_reg;
    logic signed [47:0] z2_reg;
    sllc_pkg::cs_t      clon_reg;
    sllc_pkg::cs_t      slon_reg;
    sllc_pkg::cs_t      clon2_reg;
    sllc_pkg::cs_t      slon2_reg;
    logic signed [69:0] x_prod_reg;
    logic signed [69:0] y_prod_reg;
    logic [143:0]       out_reg;
    logic signed [69:0] xr;
    logic signed [69:0] yr;
    logic signed [66:0] rcr;
    logic signed [66:0] rzr;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_reg    <= 1'b0;
            radius_reg <= sllc_pkg::RADIUS_AT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                sllc_pkg::REG_ANGLE_DEG: deg_reg    <= cfg_data[0];
                sllc_pkg::REG_RADIUS:    radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Valid shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LAT-2:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[LAT-1];
        end
    end

    sllc_angle u_lon (.aclk(aclk), .en(en), .deg(deg_reg),
                      .angle(s_axis_tdata[31:0]), .rot(lon_rot));
    sllc_angle u_lat (.aclk(aclk), .en(en), .deg(deg_reg),
                      .angle(s_axis_tdata[63:32]), .rot(lat_rot));
    sllc_cordic u_clon (.aclk(aclk), .en(en), .din(lon_rot), .cos_o(clon), .sin_o(slon));
    sllc_cordic u_clat (.aclk(aclk), .en(en), .din(lat_rot), .cos_o(clat), .sin_o(slat));

    // R = radius + altitude, delayed alongside the CORDIC
    assign r_next = 34'($signed({1'b0, radius_reg})) + 34'($signed(s_axis_tdata[95:64]));
    always_ff @(posedge aclk) begin
        if (en) begin
            r_pipe_reg[0] <= r_next;
            for (int k = 1; k < sllc_pkg::CORDIC_STAGES + 3; k++) begin
                r_pipe_reg[k] <= r_pipe_reg[k-1];
            end
        end
    end

    assign rcr = (rc_prod_reg + (67'sd1 <<< 29)) >>> 30;
    assign rzr = (rz_prod_reg + (67'sd1 <<< 29)) >>> 30;
    assign xr  = (x_prod_reg + (70'sd1 <<< 29)) >>> 30;
    assign yr  = (y_prod_reg + (70'sd1 <<< 29)) >>> 30;

    // Multiply pipeline: R*cos(lat), R*sin(lat); then rc*cos(lon), rc*sin(lon)
    always_ff @(posedge aclk) begin
        if (en) begin
            rc_prod_reg <= 67'(r_pipe_reg[sllc_pkg::CORDIC_STAGES+2]) * 67'(clat);
            rz_prod_reg <= 67'(r_pipe_reg[sllc_pkg::CORDIC_STAGES+2]) * 67'(slat);
            clon_reg    <= clon;
            slon_reg    <= slon;
            clon2_reg   <= clon_reg;
            slon2_reg   <= slon_reg;
            rc_reg      <= rcr[36:0];
            z_reg       <= rzr[47:0];
            x_prod_reg  <= 70'(rc_reg) * 70'(clon2_reg);
            y_prod_reg  <= 70'(rc_reg) * 70'(slon2_reg);
            z2_reg      <= z_reg;
            out_reg     <= {z2_reg, yr[47:0], xr[47:0]};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    // Output holds under stall, input is ready while output is empty, and no valid item is lost
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");
    a_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[LAT-1] |=> m_axis_tvalid)
        else $error("pipeline item lost");
`endif
endmodule
